### rtl/tdpg_pkg.sv
// Package for the trial-division prime generator: field widths, fixed constants,
// the sequencer state type and a divide-by-ten helper.
// No dependencies; imported by every module under rtl.
`default_nettype none

package tdpg_pkg;

    localparam int VALUE_W = 10;
    localparam int INDEX_W = 8;
    localparam int DIGIT_W = 7;
    localparam int STEP_W  = $clog2(VALUE_W + 1);

    localparam logic [VALUE_W-1:0] VALUE_MAX   = 10'd1023;
    localparam logic [VALUE_W-1:0] FIRST_PRIME = 10'd2;
    localparam logic [VALUE_W-1:0] FIRST_ODD   = 10'd3;
    localparam logic [VALUE_W-1:0] TWO_DIGIT   = 10'd10;
    localparam logic [VALUE_W-1:0] THREE_DIGIT = 10'd100;
    localparam logic [VALUE_W-1:0] FOUR_DIGIT  = 10'd1000;
    localparam logic [INDEX_W-1:0] LIMIT_RESET = 8'd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SQUARE,
        ST_CHECK,
        ST_DIVIDE,
        ST_FOUND,
        ST_FLAG,
        ST_DONE
    } state_t;

    // x / 10 for x below 1029: multiply by 205, drop 11 bits
    function automatic logic [DIGIT_W-1:0] div10(input logic [VALUE_W-1:0] x);
        logic [VALUE_W+7:0] prod;
        prod = {8'd0, x} * 18'd205;
        return prod[17:11];
    endfunction

endpackage

`default_nettype wire

### rtl/tdpg_table.sv
// Prime table: single-port-write, single-port-read memory, read data registered.
// Depends on tdpg_pkg for the entry width.
`default_nettype none

module tdpg_table #(
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [AW-1:0]                waddr,
    input  wire logic [tdpg_pkg::VALUE_W-1:0] wdata,
    input  wire logic [AW-1:0]                raddr,
    output logic      [tdpg_pkg::VALUE_W-1:0] rdata
);
    import tdpg_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/tdpg_rem.sv
// Restoring remainder unit: one dividend bit per cycle, done pulses after VALUE_W steps.
// Depends on tdpg_pkg for widths.
`default_nettype none

module tdpg_rem (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [tdpg_pkg::VALUE_W-1:0] dividend,
    input  wire logic [tdpg_pkg::VALUE_W-1:0] divisor,
    output logic                              done,
    output logic      [tdpg_pkg::VALUE_W-1:0] remainder
);
    import tdpg_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic [VALUE_W-1:0] rem_reg, rem_next;
    logic [VALUE_W-1:0] sh_reg, sh_next;
    logic [VALUE_W-1:0] dvs_reg, dvs_next;
    logic [VALUE_W:0]   trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        dvs_reg <= dvs_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, sh_reg[VALUE_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = STEP_W'(VALUE_W);
            rem_next  = '0;
            sh_next   = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = VALUE_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[VALUE_W-1:0];
            end
            sh_next  = {sh_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

### rtl/trial_division_prime_generator.sv
// Trial-division prime generator, top level.
// Depends on tdpg_pkg, tdpg_table (prime memory) and tdpg_rem (remainder unit).
//
// Input channel (in_valid/in_ready, field restart): one request per transaction.
// restart=1 clears the prime count and candidate and answers with an all-zero result;
// restart=0 asks for the next prime: 2 first, then odd candidates tested against the
// stored primes in ascending order until a stored prime's square exceeds the candidate.
// Output channel (out_valid/out_ready): one transaction per request with prime_value,
// prime_index (one-based), leading_digits_rising and exhausted. Once
// min(count_limit, PRIME_COUNT) primes are out, or no prime is left below 1024,
// answers carry exhausted=1 with zero value and index. Write count_limit through
// cfg_we/cfg_wdata only while no request is in flight.
// Timing: one request at a time. Restart and limit-exhausted answers go from ST_IDLE
// through ST_DONE into the output register; the prime 2 goes through ST_FOUND, ST_FLAG
// and ST_DONE. Each trial division steps through the table read, square, compare and
// the remainder unit, so a request's time grows with the trial divisions over all
// candidates tried. An output register parts the channels: a new request is
// accepted while a result waits; a finished result holds until the output frees up.
// Reset: count_limit returns to 100, prime count to 0, candidate to 3; the prime table
// keeps stale contents, which are never read before being rewritten.
`default_nettype none

module trial_division_prime_generator #(
    parameter int PRIME_COUNT = 128
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [tdpg_pkg::INDEX_W-1:0] cfg_wdata,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         restart,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [tdpg_pkg::VALUE_W-1:0] prime_value,
    output logic      [tdpg_pkg::INDEX_W-1:0] prime_index,
    output logic                              leading_digits_rising,
    output logic                              exhausted
);
    import tdpg_pkg::*;

    localparam int AW   = $clog2(PRIME_COUNT);
    localparam int CMPW = $clog2(PRIME_COUNT + 1) + INDEX_W;

    state_t state_reg, state_next;

    // architectural state outside the table
    logic [INDEX_W-1:0] count_limit_reg;
    logic [INDEX_W-1:0] primes_found_reg, primes_found_next;
    logic [VALUE_W-1:0] next_cand_reg, next_cand_next;

    // search datapath
    logic [VALUE_W-1:0]   cand_reg, cand_next;
    logic [INDEX_W-1:0]   idx_reg, idx_next;
    logic [VALUE_W-1:0]   p_reg, p_next;
    logic [2*VALUE_W-1:0] sq_reg, sq_next;
    logic [DIGIT_W-1:0]   lead_reg, lead_next;

    // pending result
    logic [VALUE_W-1:0] res_value_reg, res_value_next;
    logic [INDEX_W-1:0] res_index_reg, res_index_next;
    logic               res_flag_reg, res_flag_next;
    logic               res_exh_reg, res_exh_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    logic [INDEX_W-1:0] out_index_reg, out_index_next;
    logic               out_flag_reg, out_flag_next;
    logic               out_exh_reg, out_exh_next;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [AW-1:0]      mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;
    logic               rem_start;
    logic               rem_done;
    logic [VALUE_W-1:0] rem_value;

    logic [INDEX_W-1:0] limit_eff;
    logic [VALUE_W:0]   cand_plus2;
    logic [VALUE_W:0]   res_plus2;
    logic [DIGIT_W-1:0] lead_div;
    logic [DIGIT_W-1:0] tens_full;
    logic [3:0]         tens;
    logic [3:0]         ones;

    tdpg_table #(
        .DEPTH (PRIME_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (res_value_reg),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tdpg_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (cand_reg),
        .divisor   (p_reg),
        .done      (rem_done),
        .remainder (rem_value)
    );

    // effective limit: the smaller of count_limit and the table depth
    assign limit_eff = ({{(CMPW-INDEX_W){1'b0}}, count_limit_reg} > CMPW'(PRIME_COUNT))
                     ? INDEX_W'(PRIME_COUNT) : count_limit_reg;

    assign cand_plus2 = {1'b0, cand_reg} + (VALUE_W+1)'(2);
    assign res_plus2  = {1'b0, res_value_reg} + (VALUE_W+1)'(2);
    assign lead_div   = div10(res_value_reg);
    assign tens_full  = div10({{(VALUE_W-DIGIT_W){1'b0}}, lead_reg});
    assign tens       = tens_full[3:0];
    assign ones       = 4'(lead_reg - DIGIT_W'({3'd0, tens} * 7'd10));

    assign mem_raddr = AW'(idx_reg);
    assign mem_waddr = AW'(primes_found_reg);
    assign in_ready  = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_limit_reg  <= LIMIT_RESET;
            primes_found_reg <= '0;
            next_cand_reg    <= FIRST_ODD;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            primes_found_reg <= primes_found_next;
            next_cand_reg    <= next_cand_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_we)
            begin
                count_limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg      <= cand_next;
        idx_reg       <= idx_next;
        p_reg         <= p_next;
        sq_reg        <= sq_next;
        lead_reg      <= lead_next;
        res_value_reg <= res_value_next;
        res_index_reg <= res_index_next;
        res_flag_reg  <= res_flag_next;
        res_exh_reg   <= res_exh_next;
        out_value_reg <= out_value_next;
        out_index_reg <= out_index_next;
        out_flag_reg  <= out_flag_next;
        out_exh_reg   <= out_exh_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        primes_found_next = primes_found_reg;
        next_cand_next    = next_cand_reg;
        cand_next         = cand_reg;
        idx_next          = idx_reg;
        p_next            = p_reg;
        sq_next           = sq_reg;
        lead_next         = lead_reg;
        res_value_next    = res_value_reg;
        res_index_next    = res_index_reg;
        res_flag_next     = res_flag_reg;
        res_exh_next      = res_exh_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_value_next    = out_value_reg;
        out_index_next    = out_index_reg;
        out_flag_next     = out_flag_reg;
        out_exh_next      = out_exh_reg;
        mem_we            = 1'b0;
        rem_start         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    res_value_next = '0;
                    res_index_next = '0;
                    res_flag_next  = 1'b0;
                    res_exh_next   = 1'b0;
                    if (restart)
                    begin
                        primes_found_next = '0;
                        next_cand_next    = FIRST_ODD;
                        state_next        = ST_DONE;
                    end
                    else if (primes_found_reg >= limit_eff)
                    begin
                        res_exh_next = 1'b1;
                        state_next   = ST_DONE;
                    end
                    else if (primes_found_reg == '0)
                    begin
                        res_value_next = FIRST_PRIME;
                        state_next     = ST_FOUND;
                    end
                    else
                    begin
                        cand_next  = next_cand_reg;
                        idx_next   = '0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                // table address is idx_reg; data lands next cycle
                state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                p_next     = mem_rdata;
                sq_next    = mem_rdata * mem_rdata;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (p_reg < FIRST_PRIME || sq_reg > {{VALUE_W{1'b0}}, cand_reg})
                begin
                    res_value_next = cand_reg;
                    state_next     = ST_FOUND;
                end
                else
                begin
                    rem_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (rem_done)
                begin
                    if (rem_value == '0)
                    begin
                        // composite: advance to the next odd candidate or give up
                        if (cand_plus2 > {1'b0, VALUE_MAX})
                        begin
                            next_cand_next = VALUE_MAX;
                            res_exh_next   = 1'b1;
                            state_next     = ST_DONE;
                        end
                        else
                        begin
                            cand_next  = cand_plus2[VALUE_W-1:0];
                            idx_next   = '0;
                            state_next = ST_READ;
                        end
                    end
                    else if (idx_reg + INDEX_W'(1) == primes_found_reg)
                    begin
                        res_value_next = cand_reg;
                        state_next     = ST_FOUND;
                    end
                    else
                    begin
                        idx_next   = idx_reg + INDEX_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            ST_FOUND:
            begin
                // store the prime; reads of this entry only happen in later requests
                mem_we            = 1'b1;
                primes_found_next = primes_found_reg + INDEX_W'(1);
                res_index_next    = primes_found_reg + INDEX_W'(1);
                if (res_value_reg != FIRST_PRIME)
                begin
                    next_cand_next = (res_plus2 > {1'b0, VALUE_MAX})
                                   ? VALUE_MAX : res_plus2[VALUE_W-1:0];
                end
                // reduce to the two leading digits
                if (res_value_reg < THREE_DIGIT)
                begin
                    lead_next = res_value_reg[DIGIT_W-1:0];
                end
                else if (res_value_reg >= FOUR_DIGIT)
                begin
                    lead_next = DIGIT_W'(10);
                end
                else
                begin
                    lead_next = lead_div;
                end
                state_next = ST_FLAG;
            end
            ST_FLAG:
            begin
                res_flag_next = (res_value_reg >= TWO_DIGIT) && (ones > tens);
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_value_reg;
                    out_index_next = res_index_reg;
                    out_flag_next  = res_flag_reg;
                    out_exh_next   = res_exh_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid             = out_valid_reg;
    assign prime_value           = out_value_reg;
    assign prime_index           = out_index_reg;
    assign leading_digits_rising = out_flag_reg;
    assign exhausted             = out_exh_reg;

    // an exhausted answer never carries a prime
    a_exh_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && exhausted |-> prime_value == '0 && prime_index == '0)
        else $error("exhausted result carries a prime");

    // candidates stay odd
    a_cand_odd: assert property (@(posedge clk) disable iff (!rst_n)
        next_cand_reg[0] == 1'b1)
        else $error("next candidate is even");

    // each stored prime bumps the count by exactly one
    a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FOUND |=> primes_found_reg == $past(primes_found_reg) + INDEX_W'(1))
        else $error("prime count did not advance");

    // a numbered result is 2 or odd
    a_prime_odd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && prime_index != '0 |-> prime_value[0] || prime_value == FIRST_PRIME)
        else $error("even value reported as prime");

endmodule

`default_nettype wire

### test/prime_sequence_checker.sv
// Checker for the trial-division prime generator: watches both channels and the
// limit register, predicts each answer and compares it field by field.
// Depends on tdpg_pkg for field widths and constants.

module prime_sequence_checker #(
    parameter int PRIME_COUNT = 128
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [tdpg_pkg::INDEX_W-1:0] cfg_wdata,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic                         restart,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [tdpg_pkg::VALUE_W-1:0] prime_value,
    input  logic [tdpg_pkg::INDEX_W-1:0] prime_index,
    input  logic                         leading_digits_rising,
    input  logic                         exhausted,
    output int                           fail_count,
    output int                           pending,
    output int                           answers_checked,
    output int                           deepest_index
);

    localparam int TOP_VALUE  = int'(tdpg_pkg::VALUE_MAX);
    localparam int FIRST_EVEN = int'(tdpg_pkg::FIRST_PRIME);
    localparam int START_ODD  = int'(tdpg_pkg::FIRST_ODD);

    typedef struct packed {
        logic [tdpg_pkg::VALUE_W-1:0] value;
        logic [tdpg_pkg::INDEX_W-1:0] index;
        logic                         rising;
        logic                         exh;
    } answer_t;

    answer_t awaited_answers[$];

    int known_primes[PRIME_COUNT];
    int found_cnt;
    int next_cand;
    int limit_copy;
    int errors  = 0;
    int checked = 0;
    int deepest = 0;

    assign fail_count      = errors;
    assign answers_checked = checked;
    assign deepest_index   = deepest;

    function automatic logic digits_rise(input int p);
        int v;
        v = p;
        if (p < 10)
            return 1'b0;
        while (v >= 100)
            v = v / 10;
        return (v % 10) > (v / 10);
    endfunction

    function automatic bit passes_division(input int c);
        int p;
        for (int i = 0; i < found_cnt && i < PRIME_COUNT; i++)
        begin
            p = known_primes[i];
            if (p < 2 || p * p > c)
                return 1'b1;
            if (c % p == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic answer_t next_prime_answer(input logic want_restart);
        answer_t a;
        int cap;
        int c;
        int hit;
        a = '0;
        if (want_restart)
        begin
            found_cnt = 0;
            next_cand = START_ODD;
            return a;
        end
        cap = (limit_copy > PRIME_COUNT) ? PRIME_COUNT : limit_copy;
        if (found_cnt >= cap)
        begin
            a.exh = 1'b1;
            return a;
        end
        hit = 0;
        if (found_cnt == 0)
            hit = FIRST_EVEN;
        else
        begin
            c = next_cand & TOP_VALUE;
            while (c <= TOP_VALUE && hit == 0)
            begin
                if (passes_division(c))
                    hit = c;
                else
                    c += 2;
            end
            if (hit == 0)
            begin
                next_cand = TOP_VALUE;
                a.exh = 1'b1;
                return a;
            end
            next_cand = (hit + 2 > TOP_VALUE) ? TOP_VALUE : hit + 2;
        end
        if (found_cnt < PRIME_COUNT)
            known_primes[found_cnt] = hit & TOP_VALUE;
        found_cnt = (found_cnt + 1) & 8'hFF;
        a.value  = hit[tdpg_pkg::VALUE_W-1:0];
        a.index  = found_cnt[tdpg_pkg::INDEX_W-1:0];
        a.rising = digits_rise(hit);
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        answer_t want;
        if (!rst_n)
        begin
            limit_copy = int'(tdpg_pkg::LIMIT_RESET);
            found_cnt  = 0;
            next_cand  = START_ODD;
            awaited_answers.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
                limit_copy = int'(cfg_wdata);
            if (out_valid && out_ready)
            begin
                if (awaited_answers.size() == 0)
                begin
                    $error("unexpected answer: prime_value %0d prime_index %0d exhausted %0b",
                           prime_value, prime_index, exhausted);
                    errors++;
                end
                else
                begin
                    want = awaited_answers.pop_front();
                    checked++;
                    if (int'(prime_index) > deepest)
                        deepest = int'(prime_index);
                    if (prime_value !== want.value)
                    begin
                        $error("prime_value: expected %0d, got %0d", want.value, prime_value);
                        errors++;
                    end
                    if (prime_index !== want.index)
                    begin
                        $error("prime_index: expected %0d, got %0d", want.index, prime_index);
                        errors++;
                    end
                    if (leading_digits_rising !== want.rising)
                    begin
                        $error("leading_digits_rising: expected %0b, got %0b",
                               want.rising, leading_digits_rising);
                        errors++;
                    end
                    if (exhausted !== want.exh)
                    begin
                        $error("exhausted: expected %0b, got %0b", want.exh, exhausted);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
                awaited_answers.push_back(next_prime_answer(restart));
            pending <= awaited_answers.size();
        end
    end

endmodule

### test/tb.sv
// Top of the testbench for the trial-division prime generator: clock, reset,
// request and limit stimulus, answer back-pressure and the verdict.
// Depends on tdpg_pkg, trial_division_prime_generator and prime_sequence_checker.

module tb;

    localparam int PRIME_COUNT = 128;
    // run budget: allows well beyond the slowest request for every item
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int HOLD_CYCLES = 600;
    localparam int NUM_PHASES  = 5;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         cfg_we    = 1'b0;
    logic [tdpg_pkg::INDEX_W-1:0] cfg_wdata = '0;
    logic                         in_valid  = 1'b0;
    logic                         restart   = 1'b0;
    logic                         out_ready = 1'b0;

    logic                         in_ready;
    logic                         out_valid;
    logic [tdpg_pkg::VALUE_W-1:0] prime_value;
    logic [tdpg_pkg::INDEX_W-1:0] prime_index;
    logic                         leading_digits_rising;
    logic                         exhausted;

    int fail_count;
    int pending;
    int answers_checked;
    int deepest_index;

    // stimulus bookkeeping for the summary
    int requests_sent  = 0;
    int restarts_sent  = 0;
    int limit_writes   = 0;
    int cycle_count    = 0;

    // calm: no idling on either side; hold_req: one long receiver hold-off
    bit calm     = 1'b0;
    bit hold_req = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    trial_division_prime_generator #(
        .PRIME_COUNT(PRIME_COUNT)
    ) dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_wdata            (cfg_wdata),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .restart              (restart),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .prime_value          (prime_value),
        .prime_index          (prime_index),
        .leading_digits_rising(leading_digits_rising),
        .exhausted            (exhausted)
    );

    prime_sequence_checker #(
        .PRIME_COUNT(PRIME_COUNT)
    ) prime_check (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_wdata            (cfg_wdata),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .restart              (restart),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .prime_value          (prime_value),
        .prime_index          (prime_index),
        .leading_digits_rising(leading_digits_rising),
        .exhausted            (exhausted),
        .fail_count           (fail_count),
        .pending              (pending),
        .answers_checked      (answers_checked),
        .deepest_index        (deepest_index)
    );

    // Offer one request and hold it until the transaction completes.
    // A following request keeps valid high; a random gap drops it once in_ready is back.
    task automatic send_request(input logic want_restart);
        in_valid <= 1'b1;
        restart  <= want_restart;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        requests_sent++;
        if (want_restart)
            restarts_sent++;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    // Write the limit only once every answer is back and the block has settled.
    task automatic write_limit(input logic [tdpg_pkg::INDEX_W-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        limit_writes++;
    endtask

    // Receiver: random bursts of ready and stall, plus one long hold-off so the
    // block fills its output register and sequencer and drops in_ready.
    initial
    begin : answer_sink
        bit hold_done;
        hold_done = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
        end
    end

    // Watchdog: end the run if it overruns the cycle budget.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[trial_division_prime_generator] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int phase_limit[NUM_PHASES];
        int phase_items[NUM_PHASES];

        // all-ones limit runs the full table; then exact cap, random, tiny, default
        phase_limit[0] = 255;
        phase_limit[1] = PRIME_COUNT;
        phase_limit[2] = $urandom_range(1, PRIME_COUNT);
        phase_limit[3] = 2;
        phase_limit[4] = int'(tdpg_pkg::LIMIT_RESET);
        phase_items[0] = 150;
        phase_items[1] = 140;
        phase_items[2] = 60;
        phase_items[3] = 30;
        phase_items[4] = 70;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset limit: restart with nothing found, then the
        // first primes, covering single digits and both flag values.
        send_request(1'b1);
        repeat (12) send_request(1'b0);

        // Limit of one: already past it, so exhausted; restart clears exhausted.
        write_limit(8'd1);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);

        // Limit of zero: every next-prime request exhausted; a restart still answers all-zero.
        write_limit(8'd0);
        send_request(1'b0);
        send_request(1'b1);

        write_limit(8'd3);
        repeat (4) send_request(1'b0);

        // Random part: long runs of next-prime requests with rare restarts so the
        // sequence reaches deep into the table and past the limit.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph == NUM_PHASES - 1)
                calm = 1'b1;
            write_limit(phase_limit[ph][tdpg_pkg::INDEX_W-1:0]);
            if (ph == 0)
                hold_req = 1'b1;
            if (ph == 0 || $urandom_range(0, 1) == 1)
                send_request(1'b1);
            for (int k = 0; k < phase_items[ph]; k++)
                send_request($urandom_range(0, 59) == 0);
        end

        // Drain: hold off new requests until every answer is back, then settle.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("covered %0d requests (%0d restarts) over %0d limit settings",
                 requests_sent, restarts_sent, limit_writes);
        $display("checked %0d answers, deepest prime index %0d, in %0d cycles",
                 answers_checked, deepest_index, cycle_count);
        if (fail_count == 0)
            $display("[trial_division_prime_generator] OK");
        else
            $display("[trial_division_prime_generator] ERROR");
        $finish;
    end

endmodule

### files.f
rtl/tdpg_pkg.sv
rtl/tdpg_table.sv
rtl/tdpg_rem.sv
rtl/trial_division_prime_generator.sv
test/prime_sequence_checker.sv
test/tb.sv
